[design/pulse_width_frame_receiver_top_macros.svh]
// Assertion macros used by the port-level checker of the pulse width frame receiver.
`ifndef PULSE_WIDTH_FRAME_RECEIVER_TOP_MACROS_SVH
`define PULSE_WIDTH_FRAME_RECEIVER_TOP_MACROS_SVH

// Checked at every rising edge outside reset.
`define PWFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PWFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pwfr_pkg.sv]
// Package with types, constants and helpers of the pulse width frame receiver.
package pwfr_pkg;

    localparam int UNIT_W    = 8;
    localparam int DUR_W     = 16;
    localparam int ERR_W     = 16;
    localparam int Q_W       = 8;
    localparam int DIV_NUM_W = DUR_W + 2;
    localparam int DIV_DEN_W = UNIT_W + 1;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 8'd8;

    // Nominal pulse lengths in units.
    localparam logic [Q_W-1:0] LEN_START  = 8'd8;
    localparam logic [Q_W-1:0] LEN_SLAVE  = 8'd4;
    localparam logic [Q_W-1:0] LEN_MASTER = 8'd9;
    localparam logic [Q_W-1:0] LEN_HALF   = 8'd2;
    localparam logic [Q_W-1:0] LEN_FULL   = 8'd4;
    localparam logic [Q_W-1:0] LEN_STOP   = 8'd8;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    typedef enum logic [2:0] {
        PH_START0 = 3'd0,
        PH_START1 = 3'd1,
        PH_START2 = 3'd2,
        PH_HALF   = 3'd3,
        PH_FULL   = 3'd4,
        PH_STOP   = 3'd5
    } t_rx_phase;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_DIV  = 3'd1,
        ST_EVAL = 3'd2,
        ST_RES  = 3'd3,
        ST_READ = 3'd4,
        ST_EMIT = 3'd5
    } t_ctl_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

    function automatic logic len_near(input logic [Q_W-1:0] q, input logic [Q_W-1:0] e);
        return (q >= e - 8'd1) && (q <= e + 8'd1);
    endfunction

    function automatic logic len_at_least(input logic [Q_W-1:0] q, input logic [Q_W-1:0] e);
        return q >= e - 8'd1;
    endfunction

endpackage

[design/pwfr_if.sv]
// Valid/ready channel interfaces for edge beats and result beats.
interface pwfr_in_if
    import pwfr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [DUR_W-1:0] edge_duration;
    logic             tx_busy;

    modport source (output valid, cmd, edge_duration, tx_busy, input ready);
    modport sink   (input valid, cmd, edge_duration, tx_busy, output ready);
endinterface

interface pwfr_out_if
    import pwfr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [7:0]       data_byte;
    logic             last_byte;
    logic             sender_master;
    logic [ERR_W-1:0] error_count;
    logic             rejected;

    modport source (output valid, kind, data_byte, last_byte, sender_master, error_count,
                    rejected, input ready);
    modport sink   (input valid, kind, data_byte, last_byte, sender_master, error_count,
                    rejected, output ready);
endinterface

[design/pwfr_div.sv]
// Restoring divider, one quotient bit per cycle, used to round pulse lengths.
module pwfr_div
    import pwfr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int CNT_W = $clog2(DIV_NUM_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_NUM_W - 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [DIV_DEN_W-1:0] r_rem, n_rem;
    logic [DIV_NUM_W-1:0] r_num, n_num;
    logic [DIV_DEN_W-1:0] r_den, n_den;
    logic [DIV_DEN_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_num  = r_num;
        n_den  = r_den;
        trial  = {r_rem, r_num[DIV_NUM_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_num  = i_req.num;
            n_den  = i_req.den;
        end else if (r_busy) begin
            // A zero divisor always subtracts, giving an all-ones quotient that saturates.
            if (trial >= {1'b0, r_den}) begin
                n_rem = DIV_DEN_W'(trial - {1'b0, r_den});
                n_num = {r_num[DIV_NUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DIV_DEN_W-1:0];
                n_num = {r_num[DIV_NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_num <= n_num;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
endmodule

[design/pwfr_mem.sv]
// Frame byte store: one write port, one registered read port.
module pwfr_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [7:0]       i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [7:0]       o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/pulse_width_frame_receiver_top.sv]
// Top level of the pulse width frame receiver: control sequencer, frame state and output stage.
// An edge beat is accepted, then waits on the shift-subtract divider that rounds the length to
// pulse units (18 steps, then its registered done flag), then updates the frame state and then
// loads the result register once the output slot is free. A clear command or a beat rejected
// because the transmitter is busy skips the divider and goes straight to the result register.
// A finished frame is read back from the byte store one byte at a time (read, then emit),
// with last_byte on the final byte. The next edge beat is taken once the last result of the
// previous one sits in the output register; the receiver does not wait for it to be taken.
// Frame bytes are assembled in a register and written to the store whole, so the store needs
// no clearing after reset.
module pulse_width_frame_receiver_top
    import pwfr_pkg::*;
#(
    parameter int MAX_BYTES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [UNIT_W-1:0] i_cfg_data,
    pwfr_in_if.sink           i_edge,
    pwfr_out_if.source        o_result
);
    localparam int MAX_BITS = MAX_BYTES * 8;
    localparam int BC_W     = $clog2(MAX_BITS + 1);
    localparam int NB_W     = BC_W - 3;
    localparam int IDX_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    t_ctl_state        r_state, n_state;
    t_rx_phase         r_phase, n_phase;
    logic              r_last_bit, n_last_bit;
    logic [BC_W-1:0]   r_bit_cnt, n_bit_cnt;
    logic [7:0]        r_cur_byte, n_cur_byte;
    logic              r_role, n_role;
    logic [ERR_W-1:0]  r_errors, n_errors;
    logic [UNIT_W-1:0] r_pulse_unit;

    logic              r_cmd, n_cmd;
    logic              r_busy, n_busy;
    logic [Q_W-1:0]    r_q, n_q;
    logic [IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]  r_last_idx, n_last_idx;

    logic              r_out_valid, n_out_valid;
    logic              r_out_kind, n_out_kind;
    logic [7:0]        r_out_data, n_out_data;
    logic              r_out_last, n_out_last;
    logic              r_out_role, n_out_role;
    logic [ERR_W-1:0]  r_out_err, n_out_err;
    logic              r_out_rej, n_out_rej;

    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [7:0]        mem_rdata;

    logic              slot_free;
    logic              store_req;
    logic              store_inv;
    logic              done;
    logic              bit_val;
    logic [NB_W-1:0]   n_bytes;

    pwfr_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    pwfr_mem #(
        .DEPTH(MAX_BYTES),
        .IDX_W(IDX_W)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(r_rd_idx),
        .o_rdata(mem_rdata)
    );

    assign slot_free      = !r_out_valid || o_result.ready;
    assign i_edge.ready   = (r_state == ST_IDLE);
    assign n_bytes        = r_bit_cnt[BC_W-1:3];

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_last_bit  = r_last_bit;
        n_bit_cnt   = r_bit_cnt;
        n_cur_byte  = r_cur_byte;
        n_role      = r_role;
        n_errors    = r_errors;
        n_cmd       = r_cmd;
        n_busy      = r_busy;
        n_q         = r_q;
        n_rd_idx    = r_rd_idx;
        n_last_idx  = r_last_idx;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_kind  = r_out_kind;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_role  = r_out_role;
        n_out_err   = r_out_err;
        n_out_rej   = r_out_rej;
        div_req     = '0;
        mem_we      = 1'b0;
        mem_waddr   = r_bit_cnt[3 +: IDX_W];
        mem_wdata   = '0;
        mem_re      = 1'b0;
        store_req   = 1'b0;
        store_inv   = 1'b0;
        done        = 1'b0;
        bit_val     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_edge.valid) begin
                    n_cmd  = i_edge.cmd;
                    n_busy = i_edge.tx_busy;
                    if (i_edge.cmd || i_edge.tx_busy) begin
                        n_state = ST_RES;
                    end else begin
                        // Rounded length is floor((2d + u) / 2u).
                        div_req.start = 1'b1;
                        div_req.num   = {1'b0, i_edge.edge_duration, 1'b0}
                                        + DIV_NUM_W'(r_pulse_unit);
                        div_req.den   = {r_pulse_unit, 1'b0};
                        n_state       = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_q     = (|div_rsp.quot[DIV_NUM_W-1:Q_W]) ? '1 : div_rsp.quot[Q_W-1:0];
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                case (r_phase)
                    PH_START0: begin
                        if (len_near(r_q, LEN_START)) begin
                            n_phase    = PH_START1;
                            n_last_bit = 1'b0;
                            n_bit_cnt  = '0;
                            n_cur_byte = '0;
                        end else begin
                            n_errors = r_errors + 1'b1;
                        end
                    end
                    PH_START1: begin
                        if (len_near(r_q, LEN_SLAVE)) begin
                            n_phase = PH_START2;
                            n_role  = 1'b0;
                        end else if (len_near(r_q, LEN_MASTER)) begin
                            n_phase = PH_START2;
                            n_role  = 1'b1;
                        end else begin
                            n_errors = r_errors + 1'b1;
                            n_phase  = PH_START0;
                        end
                    end
                    PH_START2: begin
                        if (len_near(r_q, LEN_HALF)) begin
                            n_phase = PH_HALF;
                        end else if (len_near(r_q, LEN_FULL)) begin
                            store_req = 1'b1;
                            store_inv = 1'b1;
                            n_phase   = PH_FULL;
                        end else begin
                            n_errors = r_errors + 1'b1;
                            n_phase  = PH_START0;
                        end
                    end
                    PH_HALF: begin
                        if (len_near(r_q, LEN_HALF)) begin
                            store_req = 1'b1;
                            n_phase   = PH_FULL;
                        end else begin
                            n_errors = r_errors + 1'b1;
                            n_phase  = PH_START0;
                        end
                    end
                    PH_FULL: begin
                        if (len_near(r_q, LEN_HALF)) begin
                            n_phase = PH_HALF;
                        end else if (len_near(r_q, LEN_FULL)) begin
                            store_req = 1'b1;
                            store_inv = 1'b1;
                        end else if (!r_last_bit && len_near(r_q, LEN_STOP)
                                     && (r_bit_cnt[2:0] == 3'd0)) begin
                            n_phase = PH_STOP;
                        end else if (r_last_bit && len_at_least(r_q, LEN_STOP)
                                     && (r_bit_cnt[2:0] == 3'd0)) begin
                            done = 1'b1;
                        end else begin
                            n_errors = r_errors + 1'b1;
                            n_phase  = PH_START0;
                        end
                    end
                    PH_STOP: begin
                        // After a stop that follows a zero, any edge closes the frame.
                        done = 1'b1;
                    end
                    default: begin
                        n_phase = PH_START0;
                    end
                endcase

                // Bits past a full buffer are dropped without touching the bit state.
                if (store_req && (r_bit_cnt < BC_W'(MAX_BITS))) begin
                    bit_val    = r_last_bit ^ store_inv;
                    n_last_bit = bit_val;
                    n_bit_cnt  = r_bit_cnt + 1'b1;
                    if (r_bit_cnt[2:0] == 3'd7) begin
                        mem_we     = 1'b1;
                        mem_wdata  = {bit_val, r_cur_byte[6:0]};
                        n_cur_byte = '0;
                    end else begin
                        n_cur_byte = r_cur_byte | (8'(bit_val) << r_bit_cnt[2:0]);
                    end
                end

                n_state = ST_RES;
                if (done) begin
                    n_phase = PH_START0;
                    if (n_bytes != '0) begin
                        n_rd_idx   = '0;
                        n_last_idx = IDX_W'(n_bytes - 1'b1);
                        n_state    = ST_READ;
                    end
                end
            end
            ST_RES: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_STATUS;
                    n_out_data  = '0;
                    n_out_last  = 1'b0;
                    n_out_role  = r_role;
                    n_out_err   = r_errors;
                    n_out_rej   = r_busy && !r_cmd;
                    if (r_cmd) begin
                        n_errors = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                mem_re  = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_DATA;
                    n_out_data  = mem_rdata;
                    n_out_last  = (r_rd_idx == r_last_idx);
                    n_out_role  = r_role;
                    n_out_err   = r_errors;
                    n_out_rej   = 1'b0;
                    if (r_rd_idx == r_last_idx) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                        n_state  = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_START0;
            r_last_bit   <= 1'b0;
            r_bit_cnt    <= '0;
            r_cur_byte   <= '0;
            r_role       <= 1'b0;
            r_errors     <= '0;
            r_pulse_unit <= UNIT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_last_bit   <= n_last_bit;
            r_bit_cnt    <= n_bit_cnt;
            r_cur_byte   <= n_cur_byte;
            r_role       <= n_role;
            r_errors     <= n_errors;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_pulse_unit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_busy     <= n_busy;
        r_q        <= n_q;
        r_rd_idx   <= n_rd_idx;
        r_last_idx <= n_last_idx;
        r_out_kind <= n_out_kind;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_role <= n_out_role;
        r_out_err  <= n_out_err;
        r_out_rej  <= n_out_rej;
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.kind          = r_out_kind;
    assign o_result.data_byte     = r_out_data;
    assign o_result.last_byte     = r_out_last;
    assign o_result.sender_master = r_out_role;
    assign o_result.error_count   = r_out_err;
    assign o_result.rejected      = r_out_rej;
endmodule

[design/pwfr_checker.sv]
// Port-level checks of the pulse width frame receiver, bound to its top level.
`include "pulse_width_frame_receiver_top_macros.svh"

module pwfr_checker
    import pwfr_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_kind,
    input logic [7:0] i_out_data,
    input logic i_out_last,
    input logic i_out_rej
);
    // A beat that waits must stay offered.
    `PWFR_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result beat dropped while stalled")

    // Status beats carry no byte and never close a frame.
    `PWFR_ASSERT(a_status_clean, i_clk, i_rst_n, i_out_valid && (i_out_kind == KIND_STATUS) |-> (i_out_data == 8'd0) && !i_out_last, "status beat carries frame data")

    // Rejected edges report a status beat only.
    `PWFR_ASSERT(a_rej_status, i_clk, i_rst_n, i_out_valid && i_out_rej |-> (i_out_kind == KIND_STATUS), "rejected edge reported as data")

    // Edges are handled one at a time, so an accept drops ready for the next cycle.
    `PWFR_ASSERT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "second edge accepted while busy")

    // Reset empties the output register.
    `PWFR_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid right after reset")
endmodule

bind pulse_width_frame_receiver_top pwfr_checker u_pwfr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_edge.valid),
    .i_in_ready (i_edge.ready),
    .i_out_valid(o_result.valid),
    .i_out_ready(o_result.ready),
    .i_out_kind (o_result.kind),
    .i_out_data (o_result.data_byte),
    .i_out_last (o_result.last_byte),
    .i_out_rej  (o_result.rejected)
);
